// ----- rtl/cfr_pkg.sv -----
// ----------------------------------------------------------------------------
// cfr_pkg
// Types and constants shared by the checksummed frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned PAYLOAD_W   = 64;
	localparam int unsigned POS_W       = 4;
	localparam int unsigned APB_ADDR_W  = 3;
	localparam int unsigned APB_DATA_W  = 32;

	// Byte positions within a frame; position 0 means hunting for a header.
	localparam logic [POS_W-1:0] POS_HUNT    = 4'd0;
	localparam logic [POS_W-1:0] POS_COMMAND = 4'd1;
	localparam logic [POS_W-1:0] POS_PAY_LO  = 4'd2;
	localparam logic [POS_W-1:0] POS_PAY_HI  = 4'd9;
	localparam logic [POS_W-1:0] POS_CHECK   = 4'd10;
	localparam logic [POS_W-1:0] POS_PAD     = 4'd11;
	localparam logic [POS_W-1:0] FRAME_LEN   = 4'd12;

	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hE7;

	// Register indexes on the configuration port.
	localparam logic REG_HEADER = 1'b0;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_MISMATCH = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0]    command;
		logic [PAYLOAD_W-1:0] payload;
		logic                 status;
	} frame_result_t;

	typedef struct packed {
		logic          valid;
		frame_result_t data;
	} result_req_t;

endpackage

// ----- rtl/cfr_if.sv -----
// ----------------------------------------------------------------------------
// cfr_if
// Valid/ready channels of the frame receiver: received bytes in, frames out.
// ----------------------------------------------------------------------------
interface cfr_byte_if;
	logic                      valid;
	logic                      ready;
	logic [cfr_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_frame_if;
	logic                       valid;
	logic                       ready;
	logic [cfr_pkg::BYTE_W-1:0] command;
	logic [cfr_pkg::WORD_W-1:0] payload_low;
	logic [cfr_pkg::WORD_W-1:0] payload_high;
	logic                       status;

	modport source (output valid, output command, output payload_low,
		output payload_high, output status, input ready);
	modport sink   (input valid, input command, input payload_low,
		input payload_high, input status, output ready);
endinterface

// ----- rtl/cfr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// cfr_cfg_regs
// APB register file holding the frame header value.
// ----------------------------------------------------------------------------
module cfr_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cfr_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cfr_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cfr_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output logic [cfr_pkg::BYTE_W-1:0]     header
);

	logic [cfr_pkg::BYTE_W-1:0] header_q;
	logic                       reg_index;
	logic                       wr_en;

	assign pready    = 1'b1;
	assign reg_index = paddr[2];
	assign wr_en     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= cfr_pkg::HEADER_RESET;
		end else if (wr_en && reg_index == cfr_pkg::REG_HEADER) begin
			header_q <= pwdata[cfr_pkg::BYTE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_index)
			cfr_pkg::REG_HEADER: begin
				prdata = {{(cfr_pkg::APB_DATA_W-cfr_pkg::BYTE_W){1'b0}}, header_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign header = header_q;

endmodule

// ----- rtl/cfr_assembler.sv -----
// ----------------------------------------------------------------------------
// cfr_assembler
// Hunts for the header byte, collects the frame bytes and forms the result.
// ----------------------------------------------------------------------------
module cfr_assembler (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [cfr_pkg::BYTE_W-1:0] header,
	input  logic                       out_busy,
	cfr_byte_if.sink                   in_ch,
	output cfr_pkg::result_req_t       result
);

	logic [cfr_pkg::POS_W-1:0]     pos_q;
	logic [cfr_pkg::BYTE_W-1:0]    sum_q;
	logic [cfr_pkg::BYTE_W-1:0]    command_q;
	logic [cfr_pkg::PAYLOAD_W-1:0] payload_q;
	logic [cfr_pkg::BYTE_W-1:0]    check_q;
	logic                          take;
	logic                          hunting;
	logic [2:0]                    lane;
	logic [cfr_pkg::BYTE_W-1:0]    b;

	// Only the padding byte yields a result, so only it waits for room.
	assign in_ch.ready = !(pos_q == cfr_pkg::POS_PAD && out_busy);
	assign take        = in_ch.valid && in_ch.ready;
	assign b           = in_ch.rx_byte;
	assign hunting     = pos_q == cfr_pkg::POS_HUNT || pos_q >= cfr_pkg::FRAME_LEN;
	assign lane        = 3'(pos_q - cfr_pkg::POS_PAY_LO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= cfr_pkg::POS_HUNT;
			sum_q <= '0;
		end else if (take) begin
			if (hunting) begin
				if (b == header) begin
					sum_q <= b;
					pos_q <= cfr_pkg::POS_COMMAND;
				end else begin
					pos_q <= cfr_pkg::POS_HUNT;
				end
			end else if (pos_q < cfr_pkg::POS_CHECK) begin
				sum_q <= sum_q + b;
				pos_q <= pos_q + 4'd1;
			end else if (pos_q == cfr_pkg::POS_CHECK) begin
				pos_q <= cfr_pkg::POS_PAD;
			end else begin
				pos_q <= cfr_pkg::POS_HUNT;
			end
		end
	end

	// Every frame overwrites all holds before its result, so they need no reset.
	always_ff @(posedge clk) begin
		if (take && !hunting) begin
			if (pos_q == cfr_pkg::POS_COMMAND) begin
				command_q <= b;
			end else if (pos_q >= cfr_pkg::POS_PAY_LO && pos_q <= cfr_pkg::POS_PAY_HI) begin
				payload_q[{lane, 3'b000} +: cfr_pkg::BYTE_W] <= b;
			end else if (pos_q == cfr_pkg::POS_CHECK) begin
				check_q <= b;
			end
		end
	end

	always_comb begin
		result.valid        = take && pos_q == cfr_pkg::POS_PAD;
		result.data.command = command_q;
		result.data.payload = payload_q;
		result.data.status  = (check_q == sum_q) ? cfr_pkg::STATUS_OK
			: cfr_pkg::STATUS_MISMATCH;
	end

endmodule

// ----- rtl/cfr_out_stage.sv -----
// ----------------------------------------------------------------------------
// cfr_out_stage
// Result register that holds a decoded frame until the sink takes it.
// ----------------------------------------------------------------------------
module cfr_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfr_pkg::result_req_t result,
	output logic                 out_busy,
	cfr_frame_if.source          out_ch
);

	logic                   valid_q;
	cfr_pkg::frame_result_t data_q;

	assign out_busy = valid_q && !out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (result.valid) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			data_q <= result.data;
		end
	end

	assign out_ch.valid        = valid_q;
	assign out_ch.command      = data_q.command;
	assign out_ch.payload_low  = data_q.payload[cfr_pkg::WORD_W-1:0];
	assign out_ch.payload_high = data_q.payload[cfr_pkg::PAYLOAD_W-1:cfr_pkg::WORD_W];
	assign out_ch.status       = data_q.status;

endmodule

// ----- rtl/checksummed_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_unit
// Receives serial bytes, frames 12-byte packets and checks their checksum.
// ----------------------------------------------------------------------------
// One received byte is taken every cycle. Bytes are dropped until one equals
// the header register; that byte opens a frame of header, command, eight
// payload bytes, checksum and padding. The result appears at the output in the
// cycle after the padding byte is taken, with status set when the low eight
// bits of the sum of the first ten bytes differ from the checksum byte. The
// single result register sets the rate: a padding byte waits only while the
// previous frame is still unclaimed, and every other byte is taken at once.
// A header written during a frame applies from the next hunt onwards.
module checksummed_frame_receiver_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	cfr_byte_if.sink                       in_ch,
	cfr_frame_if.source                    out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cfr_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cfr_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cfr_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);

	logic [cfr_pkg::BYTE_W-1:0] header;
	logic                       out_busy;
	cfr_pkg::result_req_t       result;

	cfr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.header  (header)
	);

	cfr_assembler u_asm (
		.clk      (clk),
		.arst_n   (arst_n),
		.header   (header),
		.out_busy (out_busy),
		.in_ch    (in_ch),
		.result   (result)
	);

	cfr_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.result   (result),
		.out_busy (out_busy),
		.out_ch   (out_ch)
	);

endmodule

// ----- verif/tb_checksummed_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// tb_checksummed_frame_receiver_unit
// Self-checking bench for the checksummed frame receiver. Byte requests are
// fed in as well-formed frames, noise and broken frames under several header
// settings. A behavioural tracker of the framing state predicts every
// decoded frame, and each frame request on the output is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_checksummed_frame_receiver_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [cfr_pkg::APB_ADDR_W-1:0] HEADER_ADDR = {cfr_pkg::REG_HEADER, 2'b00};
	localparam int                    STALL_LIMIT  = 3000;
	localparam int                    SETTLE_CYCLES = 4;
	localparam int                    HOLD_OFF_CYCLES = 300;

	typedef logic [cfr_pkg::BYTE_W-1:0] frame_bytes_t [12];

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [cfr_pkg::APB_ADDR_W-1:0] paddr;
	logic [cfr_pkg::APB_DATA_W-1:0] pwdata;
	logic [cfr_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	cfr_byte_if  byte_ch ();
	cfr_frame_if frame_ch ();

	checksummed_frame_receiver_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (byte_ch),
		.out_ch  (frame_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Tracked copy of the block's framing state and header register.
	logic [cfr_pkg::BYTE_W-1:0]    hdr_cfg = cfr_pkg::HEADER_RESET;
	logic [cfr_pkg::POS_W-1:0]     frame_pos = cfr_pkg::POS_HUNT;
	logic [cfr_pkg::BYTE_W-1:0]    frame_sum = '0;
	logic [cfr_pkg::BYTE_W-1:0]    cmd_hold = '0;
	logic [cfr_pkg::PAYLOAD_W-1:0] pay_hold = '0;
	logic [cfr_pkg::BYTE_W-1:0]    check_hold = '0;

	cfr_pkg::frame_result_t expected_frames [$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int sink_hold_left = 0;
	bit gaps_on = 1'b1;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic void track_rx_byte(input logic [cfr_pkg::BYTE_W-1:0] b);
		cfr_pkg::frame_result_t res;
		if (frame_pos == cfr_pkg::POS_HUNT || frame_pos >= cfr_pkg::FRAME_LEN) begin
			if (b == hdr_cfg) begin
				frame_sum = b;
				frame_pos = cfr_pkg::POS_COMMAND;
			end else begin
				frame_pos = cfr_pkg::POS_HUNT;
			end
		end else if (frame_pos == cfr_pkg::POS_COMMAND) begin
			cmd_hold = b;
			pay_hold = '0;
			frame_sum = frame_sum + b;
			frame_pos = cfr_pkg::POS_PAY_LO;
		end else if (frame_pos < cfr_pkg::POS_CHECK) begin
			pay_hold[8 * (frame_pos - cfr_pkg::POS_PAY_LO) +: 8] = b;
			frame_sum = frame_sum + b;
			frame_pos = frame_pos + 1'b1;
		end else if (frame_pos == cfr_pkg::POS_CHECK) begin
			check_hold = b;
			frame_pos = cfr_pkg::POS_PAD;
		end else begin
			// The padding byte closes the frame and releases the result.
			frame_pos = cfr_pkg::POS_HUNT;
			res.command = cmd_hold;
			res.payload = pay_hold;
			res.status = (check_hold == frame_sum) ? cfr_pkg::STATUS_OK
				: cfr_pkg::STATUS_MISMATCH;
			expected_frames.push_back(res);
		end
	endfunction

	// Checking and prediction both sample pre-edge values at the rising edge.
	always @(posedge clk) begin
		cfr_pkg::frame_result_t want;
		if (frame_ch.valid && frame_ch.ready) begin
			if (expected_frames.size() == 0) begin
				report_mismatch($sformatf(
					"frame with no prediction: cmd %02h lo %08h hi %08h st %0b",
					frame_ch.command, frame_ch.payload_low, frame_ch.payload_high,
					frame_ch.status));
			end else begin
				want = expected_frames.pop_front();
				if (frame_ch.command !== want.command)
					report_mismatch($sformatf("command %02h, expected %02h",
						frame_ch.command, want.command));
				if (frame_ch.payload_low !== want.payload[cfr_pkg::WORD_W-1:0])
					report_mismatch($sformatf("payload_low %08h, expected %08h",
						frame_ch.payload_low, want.payload[cfr_pkg::WORD_W-1:0]));
				if (frame_ch.payload_high
						!== want.payload[cfr_pkg::PAYLOAD_W-1:cfr_pkg::WORD_W])
					report_mismatch($sformatf("payload_high %08h, expected %08h",
						frame_ch.payload_high,
						want.payload[cfr_pkg::PAYLOAD_W-1:cfr_pkg::WORD_W]));
				if (frame_ch.status !== want.status)
					report_mismatch($sformatf("status %0b, expected %0b",
						frame_ch.status, want.status));
			end
		end
		if (byte_ch.valid && byte_ch.ready)
			track_rx_byte(byte_ch.rx_byte);
	end

	// Receiver side: random refusals, or a long hold-off when one is asked for.
	always @(posedge clk) begin
		if (sink_hold_left > 0) begin
			frame_ch.ready <= 1'b0;
			sink_hold_left--;
		end else begin
			frame_ch.ready <= !(gaps_on && $urandom_range(99) < 6);
		end
	end

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (frame_ch.valid && frame_ch.ready)
				|| (psel && penable && pwrite && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog expired with %0d frames outstanding", expected_frames.size());
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_byte(input logic [cfr_pkg::BYTE_W-1:0] b);
		while (gaps_on && $urandom_range(99) < 6) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.rx_byte <= b;
		do @(posedge clk); while (!(byte_ch.valid && byte_ch.ready));
	endtask

	task automatic send_frame_bytes(input frame_bytes_t fb, input int first, input int last);
		for (int k = first; k <= last; k++)
			send_byte(fb[k]);
	endtask

	// Stops the sender and waits until every predicted frame has come out.
	task automatic drain_frames();
		byte_ch.valid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_header(input logic [cfr_pkg::BYTE_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= HEADER_ADDR;
		pwdata <= {{(cfr_pkg::APB_DATA_W-cfr_pkg::BYTE_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		hdr_cfg = value;
	endtask

	function automatic frame_bytes_t make_frame(input logic [cfr_pkg::BYTE_W-1:0] hdr,
			input logic [cfr_pkg::BYTE_W-1:0] cmd, input logic [cfr_pkg::PAYLOAD_W-1:0] pay,
			input bit corrupt);
		frame_bytes_t fb;
		logic [cfr_pkg::BYTE_W-1:0] sum;
		fb[0] = hdr;
		fb[1] = cmd;
		sum = hdr + cmd;
		for (int k = 0; k < 8; k++) begin
			fb[2 + k] = pay[8 * k +: 8];
			sum = sum + pay[8 * k +: 8];
		end
		fb[10] = corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum;
		fb[11] = 8'($urandom);
		return fb;
	endfunction

	function automatic logic [cfr_pkg::BYTE_W-1:0] noise_byte();
		logic [cfr_pkg::BYTE_W-1:0] b;
		b = 8'($urandom);
		if (b == hdr_cfg)
			b = b ^ 8'h01;
		return b;
	endfunction

	// A header byte inside the frame is data; the second frame fails its check.
	task automatic test_reset_header_frames();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame_bytes(make_frame(cfr_pkg::HEADER_RESET, cfr_pkg::HEADER_RESET,
			64'hFF00_E7FF_00E7_00FF, 1'b0), 0, 11);
		send_frame_bytes(make_frame(cfr_pkg::HEADER_RESET, 8'hFF, '1, 1'b1), 0, 11);
	endtask

	task automatic test_header_extremes();
		drain_frames();
		write_header(8'h00);
		send_byte(8'h01);
		send_frame_bytes(make_frame(8'h00, 8'h00, '0, 1'b0), 0, 11);
		drain_frames();
		write_header(8'hFF);
		send_byte(8'hFE);
		send_frame_bytes(make_frame(8'hFF, 8'hFF, '1, 1'b0), 0, 11);
	endtask

	// A new header written mid-frame only takes effect at the next hunt.
	task automatic test_header_write_mid_frame();
		frame_bytes_t fb;
		drain_frames();
		write_header(8'h5A);
		fb = make_frame(8'h5A, 8'($urandom), {$urandom, $urandom}, 1'b0);
		send_frame_bytes(fb, 0, 5);
		byte_ch.valid <= 1'b0;
		repeat (3) @(posedge clk);
		write_header(8'hA5);
		send_frame_bytes(fb, 6, 11);
		send_byte(8'h5A);
		send_frame_bytes(make_frame(8'hA5, 8'($urandom), {$urandom, $urandom}, 1'b0), 0, 11);
	endtask

	// The receiver refuses results for a long stretch while frames keep coming,
	// so the result register fills and the padding byte request is held back.
	task automatic test_receiver_hold_off();
		drain_frames();
		sink_hold_left = HOLD_OFF_CYCLES;
		for (int f = 0; f < 4; f++)
			send_frame_bytes(make_frame(hdr_cfg, 8'($urandom), {$urandom, $urandom},
				$urandom_range(1) == 0), 0, 11);
	endtask

	task automatic test_random_traffic();
		frame_bytes_t fb;
		int phase_bytes;
		int n;
		for (int phase = 0; phase < 8; phase++) begin
			drain_frames();
			write_header(8'($urandom));
			gaps_on = (phase != 3);
			phase_bytes = 0;
			while (phase_bytes < 75) begin
				repeat ($urandom_range(0, 2)) send_byte(noise_byte());
				fb = make_frame(hdr_cfg, 8'($urandom), {$urandom, $urandom},
					$urandom_range(3) == 0);
				// Now and then a frame is cut short and the next one runs into it.
				n = ($urandom_range(9) == 0) ? $urandom_range(1, 11) : 12;
				send_frame_bytes(fb, 0, n - 1);
				phase_bytes += n;
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.rx_byte = '0;
		frame_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_header_frames();
		test_header_extremes();
		test_header_write_mid_frame();
		test_receiver_hold_off();
		test_random_traffic();

		drain_frames();
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- checksummed_frame_receiver_unit.f -----
rtl/cfr_pkg.sv
rtl/cfr_if.sv
rtl/cfr_cfg_regs.sv
rtl/cfr_assembler.sv
rtl/cfr_out_stage.sv
rtl/checksummed_frame_receiver_unit.sv
verif/tb_checksummed_frame_receiver_unit.sv
